// ===== design/number_to_word_tokens_core_assert.svh =====
// Assertion macros shared by the checker of the number-to-word core.
// Depends on nothing; included by the checker file.
`ifndef NUMBER_TO_WORD_TOKENS_CORE_ASSERT_SVH
`define NUMBER_TO_WORD_TOKENS_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define N2W_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("n2w: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define N2W_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("n2w: next-cycle check failed");

`endif

// ===== design/n2w_pkg.sv =====
// Shared types, constants and the microcode program of the number-to-word core.
// Depends on nothing; imported by n2w_dabble, the core and the testbench.
package n2w_pkg;

    localparam int NUM_BITS   = 64;
    localparam int NUM_DIGITS = 21;               // 20 digits plus a zero pad digit
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int GRP_W      = 12;               // three digits
    localparam int UPPER_LO   = 4 * 9;            // lowest bit of the billions count
    localparam int KEY_W      = 30;
    localparam int PC_W       = 6;

    localparam logic [KEY_W-1:0] KEY_HUNDRED  = KEY_W'(100);
    localparam logic [KEY_W-1:0] KEY_THOUSAND = KEY_W'(1000);
    localparam logic [KEY_W-1:0] KEY_MILLION  = KEY_W'(1000000);
    localparam logic [KEY_W-1:0] KEY_BILLION  = KEY_W'(1000000000);

    typedef enum logic [3:0] {
        OP_CONV,
        OP_ZERO,
        OP_HUND,
        OP_H100,
        OP_TENS,
        OP_UNITS,
        OP_MAG,
        OP_BMARK,
        OP_END
    } t_op;

    typedef enum logic [1:0] {
        C_NONE,
        C_ALL_ZERO,
        C_GROUP_ZERO
    } t_cond;

    typedef enum logic [1:0] {
        MAG_THOU,
        MAG_MILL,
        MAG_BILL
    } t_mag;

    typedef struct packed {
        t_op             op;
        t_cond           cond;
        logic [PC_W-1:0] target;
        logic            shift;
        t_mag            mag;
    } t_cw;

    typedef struct packed {
        logic load;
        logic step;
        logic shift;
    } t_dab_ctl;

    // Program labels
    localparam logic [PC_W-1:0] PC_CONV     = PC_W'(0);
    localparam logic [PC_W-1:0] PC_ZERO     = PC_W'(1);
    localparam logic [PC_W-1:0] PC_G6       = PC_W'(2);
    localparam logic [PC_W-1:0] PC_G6_MAG   = PC_W'(6);
    localparam logic [PC_W-1:0] PC_G5       = PC_W'(7);
    localparam logic [PC_W-1:0] PC_G5_MAG   = PC_W'(11);
    localparam logic [PC_W-1:0] PC_G4       = PC_W'(12);
    localparam logic [PC_W-1:0] PC_G4_MAG   = PC_W'(16);
    localparam logic [PC_W-1:0] PC_G3       = PC_W'(17);
    localparam logic [PC_W-1:0] PC_G3_UNITS = PC_W'(20);
    localparam logic [PC_W-1:0] PC_BMARK    = PC_W'(21);
    localparam logic [PC_W-1:0] PC_G2       = PC_W'(22);
    localparam logic [PC_W-1:0] PC_G2_MAG   = PC_W'(26);
    localparam logic [PC_W-1:0] PC_G1       = PC_W'(27);
    localparam logic [PC_W-1:0] PC_G1_MAG   = PC_W'(31);
    localparam logic [PC_W-1:0] PC_G0       = PC_W'(32);
    localparam logic [PC_W-1:0] PC_G0_UNITS = PC_W'(35);
    localparam logic [PC_W-1:0] PC_END      = PC_W'(36);

    function automatic t_cw cw_make(input t_op op, input t_cond cond,
                                    input logic [PC_W-1:0] target,
                                    input logic shift, input t_mag mag);
        t_cw cw;
        cw.op     = op;
        cw.cond   = cond;
        cw.target = target;
        cw.shift  = shift;
        cw.mag    = mag;
        return cw;
    endfunction

    function automatic logic [KEY_W-1:0] mag_key(input t_mag mag);
        logic [KEY_W-1:0] key;
        unique case (mag)
            MAG_THOU: key = KEY_THOUSAND;
            MAG_MILL: key = KEY_MILLION;
            MAG_BILL: key = KEY_BILLION;
            default:  key = KEY_THOUSAND;
        endcase
        return key;
    endfunction

    // Control store. Each group of three digits sits at the top of the digit
    // window; its last step shifts the next group in, but for the last group.
    // A zero group jumps to its last step, which then says nothing.
    function automatic t_cw n2w_ucode(input logic [PC_W-1:0] pc);
        t_cw cw;
        unique case (pc)
            PC_CONV:       cw = cw_make(OP_CONV,  C_NONE,       PC_CONV,     1'b0, MAG_THOU);
            PC_ZERO:       cw = cw_make(OP_ZERO,  C_ALL_ZERO,   PC_END,      1'b0, MAG_THOU);
            PC_G6:         cw = cw_make(OP_HUND,  C_GROUP_ZERO, PC_G6_MAG,   1'b0, MAG_THOU);
            PC_G6 + 6'd1:  cw = cw_make(OP_H100,  C_NONE,       PC_CONV,     1'b0, MAG_THOU);
            PC_G6 + 6'd2:  cw = cw_make(OP_TENS,  C_NONE,       PC_CONV,     1'b0, MAG_THOU);
            PC_G6 + 6'd3:  cw = cw_make(OP_UNITS, C_NONE,       PC_CONV,     1'b0, MAG_THOU);
            PC_G6_MAG:     cw = cw_make(OP_MAG,   C_NONE,       PC_CONV,     1'b1, MAG_BILL);
            PC_G5:         cw = cw_make(OP_HUND,  C_GROUP_ZERO, PC_G5_MAG,   1'b0, MAG_THOU);
            PC_G5 + 6'd1:  cw = cw_make(OP_H100,  C_NONE,       PC_CONV,     1'b0, MAG_THOU);
            PC_G5 + 6'd2:  cw = cw_make(OP_TENS,  C_NONE,       PC_CONV,     1'b0, MAG_THOU);
            PC_G5 + 6'd3:  cw = cw_make(OP_UNITS, C_NONE,       PC_CONV,     1'b0, MAG_THOU);
            PC_G5_MAG:     cw = cw_make(OP_MAG,   C_NONE,       PC_CONV,     1'b1, MAG_MILL);
            PC_G4:         cw = cw_make(OP_HUND,  C_GROUP_ZERO, PC_G4_MAG,   1'b0, MAG_THOU);
            PC_G4 + 6'd1:  cw = cw_make(OP_H100,  C_NONE,       PC_CONV,     1'b0, MAG_THOU);
            PC_G4 + 6'd2:  cw = cw_make(OP_TENS,  C_NONE,       PC_CONV,     1'b0, MAG_THOU);
            PC_G4 + 6'd3:  cw = cw_make(OP_UNITS, C_NONE,       PC_CONV,     1'b0, MAG_THOU);
            PC_G4_MAG:     cw = cw_make(OP_MAG,   C_NONE,       PC_CONV,     1'b1, MAG_THOU);
            PC_G3:         cw = cw_make(OP_HUND,  C_GROUP_ZERO, PC_G3_UNITS, 1'b0, MAG_THOU);
            PC_G3 + 6'd1:  cw = cw_make(OP_H100,  C_NONE,       PC_CONV,     1'b0, MAG_THOU);
            PC_G3 + 6'd2:  cw = cw_make(OP_TENS,  C_NONE,       PC_CONV,     1'b0, MAG_THOU);
            PC_G3_UNITS:   cw = cw_make(OP_UNITS, C_NONE,       PC_CONV,     1'b1, MAG_THOU);
            PC_BMARK:      cw = cw_make(OP_BMARK, C_NONE,       PC_CONV,     1'b0, MAG_BILL);
            PC_G2:         cw = cw_make(OP_HUND,  C_GROUP_ZERO, PC_G2_MAG,   1'b0, MAG_THOU);
            PC_G2 + 6'd1:  cw = cw_make(OP_H100,  C_NONE,       PC_CONV,     1'b0, MAG_THOU);
            PC_G2 + 6'd2:  cw = cw_make(OP_TENS,  C_NONE,       PC_CONV,     1'b0, MAG_THOU);
            PC_G2 + 6'd3:  cw = cw_make(OP_UNITS, C_NONE,       PC_CONV,     1'b0, MAG_THOU);
            PC_G2_MAG:     cw = cw_make(OP_MAG,   C_NONE,       PC_CONV,     1'b1, MAG_MILL);
            PC_G1:         cw = cw_make(OP_HUND,  C_GROUP_ZERO, PC_G1_MAG,   1'b0, MAG_THOU);
            PC_G1 + 6'd1:  cw = cw_make(OP_H100,  C_NONE,       PC_CONV,     1'b0, MAG_THOU);
            PC_G1 + 6'd2:  cw = cw_make(OP_TENS,  C_NONE,       PC_CONV,     1'b0, MAG_THOU);
            PC_G1 + 6'd3:  cw = cw_make(OP_UNITS, C_NONE,       PC_CONV,     1'b0, MAG_THOU);
            PC_G1_MAG:     cw = cw_make(OP_MAG,   C_NONE,       PC_CONV,     1'b1, MAG_THOU);
            PC_G0:         cw = cw_make(OP_HUND,  C_GROUP_ZERO, PC_G0_UNITS, 1'b0, MAG_THOU);
            PC_G0 + 6'd1:  cw = cw_make(OP_H100,  C_NONE,       PC_CONV,     1'b0, MAG_THOU);
            PC_G0 + 6'd2:  cw = cw_make(OP_TENS,  C_NONE,       PC_CONV,     1'b0, MAG_THOU);
            PC_G0_UNITS:   cw = cw_make(OP_UNITS, C_NONE,       PC_CONV,     1'b0, MAG_THOU);
            default:       cw = cw_make(OP_END,   C_NONE,       PC_CONV,     1'b0, MAG_THOU);
        endcase
        return cw;
    endfunction

endpackage

// ===== design/n2w_dabble.sv =====
// Binary to BCD digit register: shift-add-3 conversion, two bits per cycle,
// and a three-digit window shift for the word sequencer. Depends on n2w_pkg.
module n2w_dabble (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  n2w_pkg::t_dab_ctl             i_ctl,
    input  logic [n2w_pkg::NUM_BITS-1:0]  i_number_value,
    output logic [n2w_pkg::BCD_W-1:0]     o_bcd,
    output logic                          o_done
);
    import n2w_pkg::*;

    localparam int STEPS = NUM_BITS / 2;
    localparam int CNT_W = $clog2(STEPS);

    logic [NUM_BITS-1:0] r_bin, n_bin;
    logic [BCD_W-1:0]    r_bcd, n_bcd;
    logic [CNT_W-1:0]    r_cnt, n_cnt;

    // Correct every digit that would overflow, then shift one binary bit in.
    function automatic logic [BCD_W-1:0] dab_bit(input logic [BCD_W-1:0] b,
                                                 input logic din);
        logic [BCD_W-1:0] a;
        a = b;
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (a[4*d +: 4] >= 4'd5) begin
                a[4*d +: 4] = a[4*d +: 4] + 4'd3;
            end
        end
        return {a[BCD_W-2:0], din};
    endfunction

    always_comb begin
        n_bin = r_bin;
        n_bcd = r_bcd;
        n_cnt = r_cnt;
        if (i_ctl.load) begin
            n_bin = i_number_value;
            n_bcd = '0;
            n_cnt = '0;
        end else if (i_ctl.step) begin
            n_bcd = dab_bit(dab_bit(r_bcd, r_bin[NUM_BITS-1]), r_bin[NUM_BITS-2]);
            n_bin = {r_bin[NUM_BITS-3:0], 2'b00};
            n_cnt = r_cnt + 1'b1;
        end else if (i_ctl.shift) begin
            n_bcd = {r_bcd[BCD_W-GRP_W-1:0], {GRP_W{1'b0}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin <= n_bin;
        r_bcd <= n_bcd;
    end

    assign o_bcd  = r_bcd;
    assign o_done = (r_cnt == CNT_W'(STEPS - 1));

endmodule

// ===== design/number_to_word_tokens_core.sv =====
// Number-to-word-key core: spells an unsigned 64-bit number as short-scale
// English dictionary keys. Depends on n2w_pkg and n2w_dabble.
//
//   channel   | handshake            | payload
//   ----------+----------------------+------------------------------
//   number in | start / busy         | i_number_value[63:0]
//   words out | o_word_valid strobe  | o_word_key[29:0], o_last_word
//
// Cycles: a number is taken when start is high and busy is low. The digit
// register converts it two bits per cycle, then the control store runs one
// step per cycle: at most 35 steps plus the end step. Zero groups jump over
// their steps. Each word is on the outputs for one cycle; the last word of a
// number appears in the same cycle that busy falls. Reset is synchronous,
// active low, and leaves the core idle. The receiver cannot stall; no stall
// exists.
module number_to_word_tokens_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [n2w_pkg::NUM_BITS-1:0]  i_number_value,
    output logic                          o_word_valid,
    output logic [n2w_pkg::KEY_W-1:0]     o_word_key,
    output logic                          o_last_word
);
    import n2w_pkg::*;

    // Sequencer state
    logic             r_busy,       n_busy;
    logic [PC_W-1:0]  r_pc,         n_pc;
    logic             r_upper_nz,   n_upper_nz;
    // One-word hold stage: a word goes out only once the next one (or the
    // end of the program) is known, so the last one can be marked.
    logic             r_pend_valid, n_pend_valid;
    logic [KEY_W-1:0] r_pend_key,   n_pend_key;
    // Output register
    logic             r_out_valid,  n_out_valid;
    logic [KEY_W-1:0] r_out_key,    n_out_key;
    logic             r_out_last,   n_out_last;

    t_cw              cw;
    t_dab_ctl         dab_ctl;
    logic [BCD_W-1:0] bcd;
    logic             dab_done;

    logic [3:0]       dig_h, dig_t, dig_u;
    logic [6:0]       tens10, rem;
    logic             grp_nz, all_nz, upper_nz, single;
    logic             emit, jump;
    logic [KEY_W-1:0] key;

    n2w_dabble u_dabble (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (dab_ctl),
        .i_number_value (i_number_value),
        .o_bcd          (bcd),
        .o_done         (dab_done)
    );

    // Fetch the control word for the current step.
    assign cw = n2w_ucode(r_pc);

    // The group being spoken always sits in the top three digits.
    assign dig_h    = bcd[BCD_W-1 -: 4];
    assign dig_t    = bcd[BCD_W-5 -: 4];
    assign dig_u    = bcd[BCD_W-9 -: 4];
    assign tens10   = {dig_t, 3'b000} + {2'b00, dig_t, 1'b0};
    assign rem      = tens10 + {3'b000, dig_u};
    assign grp_nz   = |bcd[BCD_W-1 -: GRP_W];
    assign all_nz   = |bcd;
    assign upper_nz = |bcd[BCD_W-1:UPPER_LO];
    // Remainder spoken as one key: up to twenty, or a whole ten.
    assign single   = (dig_t < 4'd2) || (dig_u == 4'd0);

    always_comb begin
        n_busy       = r_busy;
        n_pc         = r_pc;
        n_upper_nz   = r_upper_nz;
        n_pend_valid = r_pend_valid;
        n_pend_key   = r_pend_key;
        n_out_valid  = 1'b0;
        n_out_key    = r_out_key;
        n_out_last   = r_out_last;
        dab_ctl      = '0;
        emit         = 1'b0;
        key          = '0;
        jump         = 1'b0;

        if (!r_busy) begin
            // Take a new number and start the conversion.
            if (start) begin
                dab_ctl.load = 1'b1;
                n_busy       = 1'b1;
                n_pc         = PC_CONV;
            end
        end else begin
            unique case (cw.op)
                OP_CONV: begin
                    dab_ctl.step = 1'b1;
                end
                OP_ZERO: begin
                    // Zero says just "zero"; latch whether billions exist.
                    emit       = !all_nz;
                    key        = '0;
                    n_upper_nz = upper_nz;
                end
                OP_HUND: begin
                    emit = (dig_h != 4'd0);
                    key  = KEY_W'(dig_h);
                end
                OP_H100: begin
                    emit = (dig_h != 4'd0);
                    key  = KEY_HUNDRED;
                end
                OP_TENS: begin
                    if (single) begin
                        emit = (rem != 7'd0);
                        key  = KEY_W'(rem);
                    end else begin
                        emit = 1'b1;
                        key  = KEY_W'(tens10);
                    end
                end
                OP_UNITS: begin
                    emit = !single;
                    key  = KEY_W'(dig_u);
                end
                OP_MAG: begin
                    emit = grp_nz;
                    key  = mag_key(cw.mag);
                end
                OP_BMARK: begin
                    emit = r_upper_nz;
                    key  = KEY_BILLION;
                end
                OP_END: begin
                    // Flush the held word as the last one and go idle.
                    n_out_valid  = 1'b1;
                    n_out_key    = r_pend_key;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_busy       = 1'b0;
                end
                default: begin
                end
            endcase

            jump = ((cw.cond == C_ALL_ZERO) && !all_nz) ||
                   ((cw.cond == C_GROUP_ZERO) && !grp_nz);
            dab_ctl.shift = cw.shift;

            // Advance the step counter.
            if (cw.op == OP_END) begin
                n_pc = PC_CONV;
            end else if (cw.op == OP_CONV) begin
                n_pc = dab_done ? r_pc + 1'b1 : r_pc;
            end else if (jump) begin
                n_pc = cw.target;
            end else begin
                n_pc = r_pc + 1'b1;
            end

            // Push the held word out and hold the new one.
            if (emit) begin
                if (r_pend_valid) begin
                    n_out_valid = 1'b1;
                    n_out_key   = r_pend_key;
                    n_out_last  = 1'b0;
                end
                n_pend_valid = 1'b1;
                n_pend_key   = key;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_pc         <= PC_CONV;
            r_upper_nz   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_busy       <= n_busy;
            r_pc         <= n_pc;
            r_upper_nz   <= n_upper_nz;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_key <= n_pend_key;
        r_out_key  <= n_out_key;
        r_out_last <= n_out_last;
    end

    assign busy         = r_busy;
    assign o_word_valid = r_out_valid;
    assign o_word_key   = r_out_key;
    assign o_last_word  = r_out_last;

endmodule

// ===== design/n2w_checker.sv =====
// Port-level checks on the number-to-word core and the bind that attaches them.
// Depends on number_to_word_tokens_core_assert.svh and the core's ports.
`include "number_to_word_tokens_core_assert.svh"

module n2w_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_word_valid,
    input logic o_last_word
);

    // A taken number starts work at once.
    `N2W_ASSERT_NXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    // Words before the last arrive while the number is still being spelled.
    `N2W_ASSERT_IMP(a_mid_busy, i_clk, i_rst_n, o_word_valid && !o_last_word, busy)
    // The end of work always hands out the last word.
    `N2W_ASSERT_IMP(a_fell_last, i_clk, i_rst_n, $fell(busy), o_word_valid && o_last_word)
    // Nothing follows the last word in the next cycle.
    `N2W_ASSERT_NXT(a_last_gap, i_clk, i_rst_n, o_word_valid && o_last_word, !o_word_valid)

endmodule

bind number_to_word_tokens_core n2w_checker u_n2w_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .o_word_valid (o_word_valid),
    .o_last_word  (o_last_word)
);

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for number_to_word_tokens_core: spells numbers as word keys.
// Depends on n2w_pkg and the core; predicts every word key and checks each strobed word.
module testbench;
    import n2w_pkg::*;

    // One predicted word: the dictionary key and its end-of-number mark.
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic             is_last;
    } t_spoken_word;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [NUM_BITS-1:0] i_number_value;
    logic                o_word_valid;
    logic [KEY_W-1:0]    o_word_key;
    logic                o_last_word;

    t_spoken_word     pending_words[$];   // words still to come, oldest first
    logic [KEY_W-1:0] spelled_keys[$];    // keys of the number being predicted
    int unsigned      error_count;
    int unsigned      words_seen;
    bit               idle_enable;

    number_to_word_tokens_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_number_value (i_number_value),
        .o_word_valid   (o_word_valid),
        .o_word_key     (o_word_key),
        .o_last_word    (o_last_word)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Word-key predictor
    // ------------------------------------------------------------------

    // Speak one group of three digits: hundreds and "hundred", then the
    // remainder as one key when it is a teen, twenty or below, or a round
    // ten, otherwise as a tens key followed by a units key.
    function automatic void say_triple(input int unsigned v);
        int unsigned h;
        int unsigned r;
        h = v / 100;
        r = v % 100;
        if (h != 0) begin
            spelled_keys.push_back(KEY_W'(h));
            spelled_keys.push_back(KEY_HUNDRED);
        end
        if (r != 0) begin
            if (r <= 20 || r % 10 == 0) begin
                spelled_keys.push_back(KEY_W'(r));
            end else begin
                spelled_keys.push_back(KEY_W'((r / 10) * 10));
                spelled_keys.push_back(KEY_W'(r % 10));
            end
        end
    endfunction

    // A zero group says nothing, its magnitude word included.
    function automatic void say_triple_mag(input int unsigned v, input logic [KEY_W-1:0] mag);
        if (v != 0) begin
            say_triple(v);
            spelled_keys.push_back(mag);
        end
    endfunction

    // Queue the words that number n must produce, in spoken order.
    function automatic void predict_words(input logic [NUM_BITS-1:0] n);
        logic [NUM_BITS-1:0] billions;
        t_spoken_word        w;
        spelled_keys.delete();
        if (n == 0) begin
            spelled_keys.push_back(KEY_W'(0));
        end else begin
            // The count of billions is spoken as a number of its own,
            // then closed by the billion key.
            billions = n / 64'd1000000000;
            if (billions != 0) begin
                say_triple_mag(32'(billions / 64'd1000000000), KEY_BILLION);
                say_triple_mag(32'((billions / 64'd1000000) % 64'd1000), KEY_MILLION);
                say_triple_mag(32'((billions / 64'd1000) % 64'd1000), KEY_THOUSAND);
                say_triple(32'(billions % 64'd1000));
                spelled_keys.push_back(KEY_BILLION);
            end
            say_triple_mag(32'((n / 64'd1000000) % 64'd1000), KEY_MILLION);
            say_triple_mag(32'((n / 64'd1000) % 64'd1000), KEY_THOUSAND);
            say_triple(32'(n % 64'd1000));
        end
        foreach (spelled_keys[i]) begin
            w.key     = spelled_keys[i];
            w.is_last = (i == spelled_keys.size() - 1);
            pending_words.push_back(w);
        end
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t ns: %s", $time, msg);
        error_count++;
    endtask

    // Sample at the edge that ends the strobe cycle; the core cannot be
    // held off, so every strobed word must match the oldest prediction.
    always @(posedge i_clk) begin : word_check
        t_spoken_word want;
        if (i_rst_n && o_word_valid) begin
            words_seen++;
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("word %0d (key %0d) with none expected",
                                          words_seen, o_word_key));
            end else begin
                want = pending_words.pop_front();
                if (o_word_key !== want.key)
                    report_mismatch($sformatf("word %0d key: got %0d, want %0d",
                                              words_seen, o_word_key, want.key));
                if (o_last_word !== want.is_last)
                    report_mismatch($sformatf("word %0d last mark: got %b, want %b",
                                              words_seen, o_last_word, want.is_last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Raise start with the number and hold it until the core takes it.
    // Called at a clock edge; returns at the edge of acceptance.
    task automatic send_number(input logic [NUM_BITS-1:0] n);
        start          <= 1'b1;
        i_number_value <= n;
        do @(posedge i_clk); while (busy);
        predict_words(n);
    endtask

    // Drop start for a random stretch now and then so that gaps land on
    // every phase of the conversion and the word stream.
    task automatic maybe_idle();
        if (idle_enable && $urandom_range(99) < 18) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 70)) @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every predicted word has come out,
    // then let the core settle into idle.
    task automatic drain_words();
        int unsigned guard;
        start <= 1'b0;
        guard = 0;
        while (pending_words.size() != 0 && guard < 2000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (80) @(posedge i_clk);
    endtask

    // One three-digit group with a bias toward the spoken special cases.
    function automatic int unsigned pick_triple();
        int unsigned h;
        h = $urandom_range(0, 9) * 100;
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return h + $urandom_range(1, 20);
            2:       return h + 10 * $urandom_range(1, 9);
            3:       return h;
            4:       return h + $urandom_range(21, 99);
            default: return $urandom_range(0, 999);
        endcase
    endfunction

    // Build a number group by group from a random leading group downward,
    // with some groups forced to zero, so that every skip path is taken.
    function automatic logic [NUM_BITS-1:0] random_spoken_number();
        logic [NUM_BITS-1:0] v;
        int                  top;
        int unsigned         g;
        v   = 0;
        top = $urandom_range(0, 6);
        for (int i = 6; i >= 0; i--) begin
            if (i > top)
                g = 0;
            else if (i == 6)
                g = $urandom_range(0, 17);
            else if ($urandom_range(0, 3) == 0)
                g = 0;
            else
                g = pick_triple();
            v = v * 64'd1000 + 64'(g);
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Zero, the single keys, teens, round tens and split tens.
    task automatic test_small_words();
        logic [NUM_BITS-1:0] vals[$];
        vals = '{64'd0, 64'd1, 64'd13, 64'd20, 64'd21, 64'd30, 64'd99, 64'd100,
                 64'd101, 64'd115, 64'd999};
        foreach (vals[i]) begin
            send_number(vals[i]);
            maybe_idle();
        end
    endtask

    // Each magnitude alone, zero groups between, and the billions count
    // reaching its own millions and billions.
    task automatic test_magnitudes();
        logic [NUM_BITS-1:0] vals[$];
        vals = '{64'd1000, 64'd1001, 64'd1000000, 64'd1000000000,
                 64'd1000000000000, 64'd1000000000000000, 64'd1000000000000000000,
                 64'd1000000001000, 64'd10000000000000000000};
        foreach (vals[i]) begin
            send_number(vals[i]);
            maybe_idle();
        end
    endtask

    // The top of the range, the top bit alone and a number with the most words.
    task automatic test_largest_values();
        send_number(64'hFFFF_FFFF_FFFF_FFFF);
        send_number(64'h8000_0000_0000_0000);
        send_number(64'd17777777777777777777);
        send_number(64'd999999999999999999);
    endtask

    // Hold the sender off until the core is empty, then resume.
    task automatic test_drain_pause();
        send_number(random_spoken_number());
        send_number(64'd0);
        drain_words();
        send_number(random_spoken_number());
    endtask

    task automatic test_random_spoken(input int unsigned count);
        repeat (count) begin
            send_number(random_spoken_number());
            maybe_idle();
        end
    endtask

    // Keep start high throughout so each number is taken the cycle busy drops.
    task automatic test_back_to_back(input int unsigned count);
        idle_enable = 1'b0;
        repeat (count) send_number(random_spoken_number());
        idle_enable = 1'b1;
    endtask

    task automatic test_random_full_range(input int unsigned count);
        repeat (count) begin
            send_number({$urandom, $urandom});
            maybe_idle();
        end
    endtask

    task automatic test_random_small(input int unsigned count);
        repeat (count) begin
            if ($urandom_range(0, 1) == 0)
                send_number(64'($urandom_range(0, 999)));
            else
                send_number(64'($urandom_range(0, 999999)));
            maybe_idle();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        error_count    = 0;
        words_seen     = 0;
        idle_enable    = 1'b1;
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_number_value <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_small_words();
        test_magnitudes();
        test_largest_values();
        test_drain_pause();
        test_random_spoken(193);
        test_back_to_back(60);
        test_random_full_range(100);
        test_random_small(90);

        drain_words();
        if (pending_words.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", pending_words.size()));

        if (error_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

    // Stop a hung run well beyond the slowest legal one.
    initial begin
        #5000000;
        $display("testbench failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/n2w_pkg.sv
design/n2w_dabble.sv
design/number_to_word_tokens_core.sv
design/n2w_checker.sv
test/testbench.sv
